### rtl/gpac_pkg.sv
// Shared types, constants and helpers of the gamepad axis conditioner.
// Depends on nothing; every other file of the block imports it.
package gpac_pkg;

   // Raw axis fields use only their low AXIS_BITS bits
   localparam int AXIS_BITS = 16;
   localparam int AXIS_W    = 16;
   localparam int QUO_BITS  = 16;             // fraction bits of a rescaled stick value
   localparam int MAG_W     = QUO_BITS + 1;   // stick magnitude 0..1.0 in Q1.16
   localparam int GAIN_W    = 16;
   localparam int SPEED_W   = 32;
   localparam int PROD_W    = MAG_W + SPEED_W;
   localparam int ANGLE_W   = 32;
   localparam int CSR_IDX_W = 3;
   localparam int CSR_DAT_W = 32;

   // Register reset values
   localparam logic [14:0] DEADZONE_RST   = 15'd4915;
   localparam logic [14:0] TRIG_THR_RST   = 15'd3277;
   localparam logic [15:0] MOVE_GAIN_RST  = 16'd256;
   localparam logic [15:0] LOOK_GAIN_RST  = 16'd30720;
   localparam logic [15:0] FRAME_TIME_RST = 16'd1092;
   localparam logic [31:0] PITCH_MAX_RST  = 32'sd5832704;
   localparam logic [31:0] PITCH_MIN_RST  = -32'sd5832704;

   typedef enum logic [CSR_IDX_W-1:0] {
      CSR_DEADZONE   = 3'd0,
      CSR_TRIG_THR   = 3'd1,
      CSR_MOVE_GAIN  = 3'd2,
      CSR_LOOK_GAIN  = 3'd3,
      CSR_FRAME_TIME = 3'd4,
      CSR_PITCH_MAX  = 3'd5,
      CSR_PITCH_MIN  = 3'd6
   } csr_index_type;

   typedef struct packed {
      logic                     connected;
      logic signed [AXIS_W-1:0] left_x;
      logic signed [AXIS_W-1:0] left_y;
      logic signed [AXIS_W-1:0] right_x;
      logic signed [AXIS_W-1:0] right_y;
      logic signed [AXIS_W-1:0] left_trigger;
      logic signed [AXIS_W-1:0] right_trigger;
      logic                     right_bumper;
      logic                     left_bumper;
      logic                     back_button;
   } req_word_type;

   typedef struct packed {
      logic signed [31:0] move_x;
      logic               move_x_valid;
      logic signed [31:0] move_up;
      logic               move_up_valid;
      logic signed [31:0] move_fwd;
      logic               move_fwd_valid;
      logic signed [31:0] yaw_out;
      logic signed [31:0] pitch_out;
      logic               next_env;
      logic               prev_env;
      logic               reset_camera;
   } rsp_word_type;

   typedef struct packed {
      logic [CSR_IDX_W-1:0] index;
      logic [CSR_DAT_W-1:0] value;
   } csr_word_type;

   // Scale the low AXIS_BITS bits of a raw field up to signed Q1.15
   function automatic logic signed [AXIS_W-1:0] axis_q15(input logic [AXIS_W-1:0] raw);
      logic [AXIS_W-1:0] shifted;
      shifted = raw << (AXIS_W - AXIS_BITS);
      return $signed(shifted);
   endfunction

   // Map a trigger from -1..1 to 0..1 in Q0.16, zero at or below the threshold
   function automatic logic [15:0] trigger_q16(input logic [AXIS_W-1:0] raw,
                                                input logic [14:0] thr);
      logic [AXIS_W-1:0] v;
      logic [15:0]       t;
      v = axis_q15(raw);
      t = {~v[15], v[14:0]};
      return (t > {thr, 1'b0}) ? t : 16'd0;
   endfunction

endpackage

### rtl/gpac_channels.sv
// Handshake channels of the gamepad axis conditioner: poll words, result words, CSR writes.
// Depends on gpac_pkg for the payload types.
interface gpac_req_if;
   import gpac_pkg::*;
   logic         valid;
   logic         ready;
   req_word_type data;
   modport source (output valid, output data, input ready);
   modport sink   (input valid, input data, output ready);
endinterface

interface gpac_rsp_if;
   import gpac_pkg::*;
   logic         valid;
   logic         ready;
   rsp_word_type data;
   modport source (output valid, output data, input ready);
   modport sink   (input valid, input data, output ready);
endinterface

interface gpac_csr_if;
   import gpac_pkg::*;
   logic         valid;
   logic         ready;
   csr_word_type data;
   modport source (output valid, output data, input ready);
   modport sink   (input valid, input data, output ready);
endinterface

### rtl/gamepad_axis_conditioner_unit.sv
// Top level of the gamepad axis conditioner: sequencer, shared multiplier, state, CSRs.
// Depends on gpac_pkg, the channel interfaces in gpac_channels and the divider gpac_div.
//
// One poll word is taken at a time. For a connected poll, the four stick axes pass one by one
// through the shared restoring divider (one quotient bit per cycle), then six products go
// through the single 17x32 multiplier, one per cycle, followed by a drain, a pitch clamp
// and a result state, in which its result word is registered. A disconnected poll goes
// straight to the result state. The result register lets the sequencer take the next poll
// while a result is still waiting to be read; a new result is held back only while the
// previous one is still unread. CSR writes are taken every cycle.
module gamepad_axis_conditioner_unit (
   input logic   clock,
   input logic   reset,
   gpac_req_if.sink   req_ch,
   gpac_rsp_if.source rsp_ch,
   gpac_csr_if.sink   csr_ch
);
   import gpac_pkg::*;

   typedef enum logic [2:0] {
      S_IDLE,
      S_DIV_START,
      S_DIV_WAIT,
      S_MUL,
      S_DRAIN,
      S_CLAMP,
      S_RESULT
   } state_type;

   typedef enum logic [2:0] {
      OP_SPEED,
      OP_MX,
      OP_MF,
      OP_MU,
      OP_YAW,
      OP_PITCH
   } op_type;

   // Configuration registers
   logic [14:0]             deadzone_ff;
   logic [14:0]             trig_thr_ff;
   logic [GAIN_W-1:0]       move_gain_ff;
   logic [GAIN_W-1:0]       look_gain_ff;
   logic [GAIN_W-1:0]       frame_time_ff;
   logic signed [ANGLE_W-1:0] pitch_max_ff;
   logic signed [ANGLE_W-1:0] pitch_min_ff;

   // Sequencer and working registers
   state_type               state_ff;
   op_type                  op_ff;
   logic [1:0]              axis_ff;
   req_word_type            item_ff;
   logic [MAG_W-1:0]        mag_ff [4];
   logic [3:0]              neg_ff;
   logic [SPEED_W-1:0]      speed_ff;
   logic [PROD_W-1:0]       prod_ff;
   op_type                  prod_op_ff;
   logic                    prod_vld_ff;
   logic signed [31:0]      mx_ff;
   logic signed [31:0]      mf_ff;
   logic signed [31:0]      mu_ff;
   logic signed [ANGLE_W:0] pitch_sum_ff;

   // Persistent state
   logic [2:0]              last_buttons_ff;
   logic [ANGLE_W-1:0]      yaw_ff;
   logic signed [ANGLE_W-1:0] pitch_ff;

   // Result register
   logic                    rsp_valid_ff;
   rsp_word_type            rsp_data_ff;

   // Combinational helpers
   logic [AXIS_W-1:0]       axis_raw;
   logic signed [AXIS_W-1:0] axis_v;
   logic                    axis_neg;
   logic [15:0]             axis_mag;
   logic [15:0]             div_dividend;
   logic [15:0]             div_divisor;
   logic                    div_start;
   logic                    div_done;
   logic [MAG_W-1:0]        div_quotient;
   logic [15:0]             lt_q16;
   logic [15:0]             rt_q16;
   logic signed [16:0]      trig_diff;
   logic                    mu_neg;
   logic [15:0]             mu_mag;
   logic                    mu_valid;
   logic [MAG_W-1:0]        mul_a;
   logic [SPEED_W-1:0]      mul_b;
   logic [31:0]             move_q;
   logic [ANGLE_W-1:0]      look_q;
   logic signed [ANGLE_W:0] look_q33;
   logic signed [ANGLE_W:0] pitch33;
   logic signed [ANGLE_W:0] pmax33;
   logic signed [ANGLE_W:0] pmin33;
   logic signed [ANGLE_W:0] clamp_hi;
   logic signed [ANGLE_W:0] clamp_lo;
   logic                    look_active;
   logic [2:0]              buttons_now;
   logic [2:0]              edges;
   logic                    out_free;
   logic                    req_fire;

   assign req_ch.ready = (state_ff == S_IDLE);
   assign req_fire     = req_ch.valid && req_ch.ready;
   assign csr_ch.ready = 1'b1;
   assign out_free     = !rsp_valid_ff || rsp_ch.ready;

   // Select the stick axis that goes to the divider next
   always_comb begin
      case (axis_ff)
         2'd0:    axis_raw = item_ff.left_x;
         2'd1:    axis_raw = item_ff.left_y;
         2'd2:    axis_raw = item_ff.right_x;
         default: axis_raw = item_ff.right_y;
      endcase
      axis_v       = axis_q15(axis_raw);
      axis_neg     = axis_v[AXIS_W-1];
      axis_mag     = axis_neg ? 16'(~axis_v + 1'b1) : axis_v;
      div_dividend = (axis_mag >= {1'b0, deadzone_ff}) ? 16'(axis_mag - {1'b0, deadzone_ff})
                                                       : 16'd0;
      div_divisor  = 16'h8000 - {1'b0, deadzone_ff};
   end

   assign div_start = (state_ff == S_DIV_START);

   gpac_div u_div (
      .clock    (clock),
      .reset    (reset),
      .start    (div_start),
      .dividend (div_dividend),
      .divisor  (div_divisor),
      .done     (div_done),
      .quotient (div_quotient)
   );

   // Triggers and their difference for the vertical move
   always_comb begin
      lt_q16    = trigger_q16(item_ff.left_trigger, trig_thr_ff);
      rt_q16    = trigger_q16(item_ff.right_trigger, trig_thr_ff);
      trig_diff = $signed({1'b0, rt_q16}) - $signed({1'b0, lt_q16});
      mu_neg    = trig_diff[16];
      mu_mag    = mu_neg ? 16'(-trig_diff) : trig_diff[15:0];
      mu_valid  = (lt_q16 != 16'd0) || (rt_q16 != 16'd0);
   end

   // Operand select for the shared multiplier
   always_comb begin
      unique case (op_ff)
         OP_SPEED: begin
            mul_a = MAG_W'(look_gain_ff);
            mul_b = SPEED_W'(frame_time_ff);
         end
         OP_MX: begin
            mul_a = mag_ff[0];
            mul_b = SPEED_W'(move_gain_ff);
         end
         OP_MF: begin
            mul_a = mag_ff[1];
            mul_b = SPEED_W'(move_gain_ff);
         end
         OP_MU: begin
            mul_a = MAG_W'(mu_mag);
            mul_b = SPEED_W'(move_gain_ff);
         end
         OP_YAW: begin
            mul_a = mag_ff[2];
            mul_b = speed_ff;
         end
         OP_PITCH: begin
            mul_a = mag_ff[3];
            mul_b = speed_ff;
         end
         default: begin
            mul_a = '0;
            mul_b = '0;
         end
      endcase
   end

   // Truncated magnitudes taken from the product register, and the pitch clamp
   always_comb begin
      move_q   = prod_ff[39:8];
      look_q   = ANGLE_W'(prod_ff[PROD_W-1:24]);
      look_q33 = $signed({1'b0, look_q});
      pitch33  = $signed({pitch_ff[ANGLE_W-1], pitch_ff});
      pmax33   = $signed({pitch_max_ff[ANGLE_W-1], pitch_max_ff});
      pmin33   = $signed({pitch_min_ff[ANGLE_W-1], pitch_min_ff});
      clamp_hi = (pitch_sum_ff > pmax33) ? pmax33 : pitch_sum_ff;
      clamp_lo = (clamp_hi < pmin33) ? pmin33 : clamp_hi;
   end

   assign look_active = (mag_ff[2] != '0) || (mag_ff[3] != '0);
   assign buttons_now = {item_ff.back_button, item_ff.left_bumper, item_ff.right_bumper};
   assign edges       = buttons_now & ~last_buttons_ff;

   // Write configuration registers
   always_ff @(posedge clock) begin
      if (reset) begin
         deadzone_ff   <= DEADZONE_RST;
         trig_thr_ff   <= TRIG_THR_RST;
         move_gain_ff  <= MOVE_GAIN_RST;
         look_gain_ff  <= LOOK_GAIN_RST;
         frame_time_ff <= FRAME_TIME_RST;
         pitch_max_ff  <= PITCH_MAX_RST;
         pitch_min_ff  <= PITCH_MIN_RST;
      end else if (csr_ch.valid && csr_ch.ready) begin
         unique case (csr_ch.data.index)
            CSR_DEADZONE:   deadzone_ff   <= csr_ch.data.value[14:0];
            CSR_TRIG_THR:   trig_thr_ff   <= csr_ch.data.value[14:0];
            CSR_MOVE_GAIN:  move_gain_ff  <= csr_ch.data.value[15:0];
            CSR_LOOK_GAIN:  look_gain_ff  <= csr_ch.data.value[15:0];
            CSR_FRAME_TIME: frame_time_ff <= csr_ch.data.value[15:0];
            CSR_PITCH_MAX:  pitch_max_ff  <= csr_ch.data.value;
            CSR_PITCH_MIN:  pitch_min_ff  <= csr_ch.data.value;
            default: ;
         endcase
      end
   end

   // Multiplier pipeline register and the consumers of its product
   always_ff @(posedge clock) begin
      if (reset) begin
         prod_vld_ff <= 1'b0;
         yaw_ff      <= '0;
      end else begin
         prod_vld_ff <= (state_ff == S_MUL);
         prod_op_ff  <= op_ff;
         prod_ff     <= mul_a * mul_b;
         if (prod_vld_ff) begin
            case (prod_op_ff)
               OP_SPEED: speed_ff <= prod_ff[SPEED_W-1:0];
               OP_MX:    mx_ff    <= neg_ff[0] ? -$signed(move_q) : $signed(move_q);
               OP_MF:    mf_ff    <= neg_ff[1] ? $signed(move_q) : -$signed(move_q);
               OP_MU:    mu_ff    <= mu_neg ? -$signed(move_q) : $signed(move_q);
               OP_YAW:   yaw_ff   <= neg_ff[2] ? yaw_ff - look_q : yaw_ff + look_q;
               OP_PITCH: pitch_sum_ff <= neg_ff[3] ? pitch33 + look_q33 : pitch33 - look_q33;
               default: ;
            endcase
         end
      end
   end

   // Sequencer, persistent state and result register
   always_ff @(posedge clock) begin
      if (reset) begin
         state_ff        <= S_IDLE;
         op_ff           <= OP_SPEED;
         axis_ff         <= 2'd0;
         rsp_valid_ff    <= 1'b0;
         last_buttons_ff <= 3'b000;
         pitch_ff        <= '0;
      end else begin
         // raise the result flag when a word is loaded, drop it once taken
         if (state_ff == S_RESULT && out_free) begin
            rsp_valid_ff <= 1'b1;
         end else if (rsp_ch.ready) begin
            rsp_valid_ff <= 1'b0;
         end
         unique case (state_ff)
            S_IDLE: begin
               if (req_fire) begin
                  item_ff  <= req_ch.data;
                  axis_ff  <= 2'd0;
                  state_ff <= req_ch.data.connected ? S_DIV_START : S_RESULT;
               end
            end
            S_DIV_START: begin
               neg_ff[axis_ff] <= axis_neg;
               state_ff        <= S_DIV_WAIT;
            end
            S_DIV_WAIT: begin
               if (div_done) begin
                  mag_ff[axis_ff] <= div_quotient;
                  if (axis_ff == 2'd3) begin
                     op_ff    <= OP_SPEED;
                     state_ff <= S_MUL;
                  end else begin
                     axis_ff  <= axis_ff + 2'd1;
                     state_ff <= S_DIV_START;
                  end
               end
            end
            S_MUL: begin
               // advance through the products, one per cycle
               if (op_ff == OP_PITCH) begin
                  state_ff <= S_DRAIN;
               end else begin
                  op_ff <= op_type'(op_ff + 3'd1);
               end
            end
            S_DRAIN: begin
               state_ff <= S_CLAMP;
            end
            S_CLAMP: begin
               // hold pitch when the right stick is idle
               if (look_active) begin
                  pitch_ff <= clamp_lo[ANGLE_W-1:0];
               end
               state_ff <= S_RESULT;
            end
            S_RESULT: begin
               if (out_free) begin
                  rsp_data_ff.move_x         <= item_ff.connected ? mx_ff : '0;
                  rsp_data_ff.move_x_valid   <= item_ff.connected && (mag_ff[0] != '0);
                  rsp_data_ff.move_up        <= (item_ff.connected && mu_valid) ? mu_ff : '0;
                  rsp_data_ff.move_up_valid  <= item_ff.connected && mu_valid;
                  rsp_data_ff.move_fwd       <= item_ff.connected ? mf_ff : '0;
                  rsp_data_ff.move_fwd_valid <= item_ff.connected && (mag_ff[1] != '0);
                  rsp_data_ff.yaw_out        <= yaw_ff;
                  rsp_data_ff.pitch_out      <= pitch_ff;
                  rsp_data_ff.next_env       <= item_ff.connected && edges[0];
                  rsp_data_ff.prev_env       <= item_ff.connected && edges[1];
                  rsp_data_ff.reset_camera   <= item_ff.connected && edges[2];
                  if (item_ff.connected) begin
                     last_buttons_ff <= buttons_now;
                  end
                  state_ff <= S_IDLE;
               end
            end
            default: state_ff <= S_IDLE;
         endcase
      end
   end

   assign rsp_ch.valid = rsp_valid_ff;
   assign rsp_ch.data  = rsp_data_ff;

   // The divider only reports a quotient while the sequencer waits for it
   a_div_done_in_wait: assert property (@(posedge clock) disable iff (reset)
      div_done |-> (state_ff == S_DIV_WAIT))
      else $error("divider finished outside the wait state");

   // A move field is zero whenever its valid bit is clear
   a_move_zero: assert property (@(posedge clock) disable iff (reset)
      rsp_valid_ff |-> ((rsp_data_ff.move_x_valid || rsp_data_ff.move_x == '0) &&
                        (rsp_data_ff.move_up_valid || rsp_data_ff.move_up == '0) &&
                        (rsp_data_ff.move_fwd_valid || rsp_data_ff.move_fwd == '0)))
      else $error("move field nonzero with valid bit clear");

   // After a clamp with consistent limits the pitch lies between them
   a_pitch_limits: assert property (@(posedge clock) disable iff (reset)
      (state_ff == S_CLAMP && look_active && pitch_min_ff <= pitch_max_ff) |=>
         (pitch_ff <= $past(pitch_max_ff) && pitch_ff >= $past(pitch_min_ff)))
      else $error("pitch outside its limits after clamp");

   // A new poll is never taken while a product is still in flight
   a_idle_quiet: assert property (@(posedge clock) disable iff (reset)
      req_fire |-> !prod_vld_ff)
      else $error("poll accepted with multiplier busy");

endmodule

### rtl/gpac_div.sv
// Restoring divider for the stick rescale: (dividend << 16) / divisor, one bit per cycle.
// Depends on gpac_pkg for widths. Requires dividend <= divisor, so the quotient is <= 1.0.
module gpac_div (
   input  logic                      clock,
   input  logic                      reset,
   input  logic                      start,
   input  logic [15:0]               dividend,
   input  logic [15:0]               divisor,
   output logic                      done,
   output logic [gpac_pkg::MAG_W-1:0] quotient
);
   import gpac_pkg::*;

   localparam int CNT_W = $clog2(QUO_BITS + 1);

   logic             busy_ff;
   logic             done_ff;
   logic [CNT_W-1:0] count_ff;
   logic [15:0]      rem_ff;
   logic [15:0]      divisor_ff;
   logic [MAG_W-1:0] quo_ff;

   logic [16:0]      rem_shift;
   logic             bit_in;
   logic [15:0]      rem_in;
   logic             top_bit;

   // Integer bit of the quotient, decided at start
   assign top_bit = (dividend >= divisor);

   // One restoring step on the partial remainder
   always_comb begin
      rem_shift = {rem_ff, 1'b0};
      bit_in    = (rem_shift >= {1'b0, divisor_ff});
      rem_in    = bit_in ? 16'(rem_shift - {1'b0, divisor_ff}) : rem_shift[15:0];
   end

   always_ff @(posedge clock) begin
      if (reset) begin
         busy_ff  <= 1'b0;
         done_ff  <= 1'b0;
         count_ff <= '0;
      end else begin
         done_ff <= 1'b0;
         if (start) begin
            busy_ff    <= 1'b1;
            count_ff   <= CNT_W'(QUO_BITS);
            divisor_ff <= divisor;
            rem_ff     <= top_bit ? 16'(dividend - divisor) : dividend;
            quo_ff     <= {{(MAG_W-1){1'b0}}, top_bit};
         end else if (busy_ff) begin
            rem_ff   <= rem_in;
            quo_ff   <= {quo_ff[MAG_W-2:0], bit_in};
            count_ff <= count_ff - 1'b1;
            if (count_ff == CNT_W'(1)) begin
               busy_ff <= 1'b0;
               done_ff <= 1'b1;
            end
         end
      end
   end

   assign done     = done_ff;
   assign quotient = quo_ff;

endmodule
